// ===== sv/lpc_pkg.sv =====
package lpc_pkg;

	// Build constants
	localparam int FIFO_DEPTH = 8;
	localparam int TIMER_BITS = 16;

	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 2;
	localparam int ACT_W   = 3;
	localparam int CNT_W   = 20;
	localparam int MODE_W  = 2;
	localparam int QCNT_W  = 4;
	localparam int FILL_W  = $clog2(FIFO_DEPTH + 1);
	localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CMP_W   = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	localparam logic [TIMER_BITS-1:0] TMR_MAX = '1;
	localparam logic [PTR_W-1:0]      PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [FILL_W-1:0]     FILL_FULL = FILL_W'(FIFO_DEPTH);

	// Register indexes
	localparam logic [CIDX_W-1:0] CFG_BLINK_ON  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_BLINK_GAP = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_TOGGLE    = 2'd2;

	localparam logic [CFG_W-1:0] BLINK_ON_RST  = 16'd100;
	localparam logic [CFG_W-1:0] BLINK_GAP_RST = 16'd100;
	localparam logic [CFG_W-1:0] TOGGLE_RST    = 16'd500;

	// Action codes; anything above ACT_HOLD behaves as hold
	localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ON     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_OFF    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_TOGGLE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_BLINK  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_HOLD   = 3'd5;

	// Reported mode codes
	localparam logic [MODE_W-1:0] MODE_CODE_STEADY = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CODE_TOGGLE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CODE_BLINK  = 2'd2;

	typedef enum logic [2:0] {
		RUN_STEADY = 3'b001,
		RUN_TOGGLE = 3'b010,
		RUN_BLINK  = 3'b100
	} run_mode_t;

	// Net level effect of a run of queued on/off/toggle/hold requests
	typedef enum logic [1:0] {
		LVL_KEEP = 2'd0,
		LVL_ON   = 2'd1,
		LVL_OFF  = 2'd2
	} lvl_set_t;

	// A queued segment: non-blink requests collapsed, closed by one blink
	typedef struct packed {
		lvl_set_t          lvl;
		logic [FILL_W-1:0] ncmd;
		logic [CNT_W-1:0]  cnt;
	} seg_t;

	typedef struct packed {
		logic              led_level;
		logic [MODE_W-1:0] mode;
		logic              dropped;
		logic [QCNT_W-1:0] queued;
	} res_t;

	function automatic logic apply_lvl(lvl_set_t s, logic cur);
		logic r;
		r = cur;
		unique case (s)
			LVL_ON:   r = 1'b1;
			LVL_OFF:  r = 1'b0;
			LVL_KEEP: r = cur;
			default:  r = cur;
		endcase
		return r;
	endfunction

	function automatic logic [MODE_W-1:0] mode_code(run_mode_t m);
		logic [MODE_W-1:0] r;
		r = MODE_CODE_STEADY;
		unique case (m)
			RUN_STEADY: r = MODE_CODE_STEADY;
			RUN_TOGGLE: r = MODE_CODE_TOGGLE;
			RUN_BLINK:  r = MODE_CODE_BLINK;
			default:    r = MODE_CODE_STEADY;
		endcase
		return r;
	endfunction

	// Timer reached its limit; limits above the timer range act as its max
	function automatic logic timer_done(logic [TIMER_BITS-1:0] t, logic [CFG_W-1:0] lim);
		return (CMP_W'(t) >= CMP_W'(lim)) || (t == TMR_MAX);
	endfunction

endpackage

// ===== sv/led_pattern_controller.sv =====
// LED pattern controller: drives one LED level from a stream of requests.
// Input channel (in_valid/in_ready): action and blink_count. Action 0 is a
// millisecond tick, 1 on, 2 off, 3 toggle, 4 blink, 5 hold (6, 7 as hold).
// Output channel (out_valid/out_ready): one result per request with the
// LED level, the mode, a drop flag and the number of queued requests.
// Config port: cfg_write with cfg_index/cfg_data; the user must write it only
// while idle, which the block does not enforce. Indexes 0..2 are blink on time,
// blink gap and toggle half period. The result is registered (result register,
// or skid while the receiver stalls). Throughput: one request per cycle while
// in_ready is high, set by the single state update before the result register.
// Requests that arrive during a blink sequence are queued. The queue keeps
// non-blink requests folded into segments closed by a blink, so the end of
// a sequence pops one segment however many requests it held.
// Receiver stall: a two-entry output buffer (result register plus skid)
// keeps in_ready high while one result waits; it drops only when both fill.
// Reset (arst_n low): LED off, steady mode, queue empty, timers at 0 and the
// config registers at 100 / 100 / 500 ticks.
module led_pattern_controller
	import lpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [CNT_W-1:0]  blink_count,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              led_level,
	output logic [MODE_W-1:0] mode,
	output logic              command_dropped,
	output logic [QCNT_W-1:0] queued_commands,
	input  logic              cfg_write,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	// config registers
	logic [CFG_W-1:0] blink_on_q, blink_gap_q, toggle_half_q;

	// LED state
	logic                  level_q, level_d;
	run_mode_t             mode_q, mode_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d, timer_inc;
	logic [CNT_W-1:0]      left_q, left_d;
	logic                  in_gap_q, in_gap_d;

	// queue bookkeeping
	logic [FILL_W-1:0] fill_q, fill_d;
	seg_t              seg_mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  seg_head_q, seg_tail_q;
	logic [FILL_W-1:0] seg_cnt_q;
	seg_t              seg_head, seg_new;
	logic              seg_push, seg_pop;

	// open segment: requests queued after the last queued blink
	lvl_set_t          open_lvl_q, open_lvl_d;
	logic              open_tgl_q, open_tgl_d;
	logic [FILL_W-1:0] open_cnt_q, open_cnt_d;

	// output buffer
	res_t res_new, out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic accept, take;
	logic dropped;
	logic [FILL_W+QCNT_W-1:0] fill_ext;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;
	assign take     = out_valid_q && out_ready;

	assign timer_inc = (timer_q == TMR_MAX) ? timer_q : timer_q + 1'b1;
	assign seg_head  = seg_mem_q[seg_head_q];

	always_comb begin
		level_d    = level_q;
		mode_d     = mode_q;
		timer_d    = timer_q;
		left_d     = left_q;
		in_gap_d   = in_gap_q;
		fill_d     = fill_q;
		open_lvl_d = open_lvl_q;
		open_tgl_d = open_tgl_q;
		open_cnt_d = open_cnt_q;
		seg_push   = 1'b0;
		seg_pop    = 1'b0;
		dropped    = 1'b0;
		seg_new.lvl  = open_lvl_q;
		seg_new.ncmd = open_cnt_q + 1'b1;
		seg_new.cnt  = (blink_count == '0) ? CNT_W'(1) : blink_count;

		if (accept) begin
			if (action == ACT_TICK) begin
				unique case (mode_q)
					RUN_TOGGLE: begin
						timer_d = timer_inc;
						if (timer_done(timer_inc, toggle_half_q)) begin
							level_d = !level_q;
							timer_d = '0;
						end
					end
					RUN_BLINK: begin
						timer_d = timer_inc;
						if (!in_gap_q) begin
							if (timer_done(timer_inc, blink_on_q)) begin
								timer_d = '0;
								if (left_q <= CNT_W'(1)) begin
									// last inversion over: run queued requests up to next blink
									if (seg_cnt_q != '0) begin
										seg_pop  = 1'b1;
										level_d  = !apply_lvl(seg_head.lvl, !level_q);
										left_d   = seg_head.cnt;
										in_gap_d = 1'b0;
										fill_d   = fill_q - seg_head.ncmd;
									end else begin
										left_d     = '0;
										level_d    = apply_lvl(open_lvl_q, !level_q);
										mode_d     = (open_cnt_q != '0 && open_tgl_q) ?
											RUN_TOGGLE : RUN_STEADY;
										fill_d     = '0;
										open_lvl_d = LVL_KEEP;
										open_tgl_d = 1'b0;
										open_cnt_d = '0;
									end
								end else begin
									level_d  = !level_q;
									left_d   = left_q - 1'b1;
									in_gap_d = 1'b1;
								end
							end
						end else if (timer_done(timer_inc, blink_gap_q)) begin
							level_d  = !level_q;
							timer_d  = '0;
							in_gap_d = 1'b0;
						end
					end
					RUN_STEADY: ;
					default: ;
				endcase
			end else if (mode_q == RUN_BLINK) begin
				if (fill_q >= FILL_FULL) begin
					dropped = 1'b1;
				end else begin
					fill_d = fill_q + 1'b1;
					unique case (action)
						ACT_BLINK: begin
							seg_push   = 1'b1;
							open_lvl_d = LVL_KEEP;
							open_tgl_d = 1'b0;
							open_cnt_d = '0;
						end
						ACT_ON: begin
							open_lvl_d = LVL_ON;
							open_tgl_d = 1'b0;
							open_cnt_d = open_cnt_q + 1'b1;
						end
						ACT_OFF: begin
							open_lvl_d = LVL_OFF;
							open_tgl_d = 1'b0;
							open_cnt_d = open_cnt_q + 1'b1;
						end
						ACT_TOGGLE: begin
							open_tgl_d = 1'b1;
							open_cnt_d = open_cnt_q + 1'b1;
						end
						default: begin
							open_tgl_d = 1'b0;
							open_cnt_d = open_cnt_q + 1'b1;
						end
					endcase
				end
			end else begin
				unique case (action)
					ACT_ON: begin
						level_d = 1'b1;
						mode_d  = RUN_STEADY;
					end
					ACT_OFF: begin
						level_d = 1'b0;
						mode_d  = RUN_STEADY;
					end
					ACT_TOGGLE: begin
						mode_d  = RUN_TOGGLE;
						timer_d = '0;
					end
					ACT_BLINK: begin
						left_d   = seg_new.cnt;
						level_d  = !level_q;
						in_gap_d = 1'b0;
						timer_d  = '0;
						mode_d   = RUN_BLINK;
					end
					default: mode_d = RUN_STEADY;
				endcase
			end
		end
	end

	assign fill_ext          = {{QCNT_W{1'b0}}, fill_d};
	assign res_new.led_level = level_d;
	assign res_new.mode      = mode_code(mode_d);
	assign res_new.dropped   = dropped;
	assign res_new.queued    = fill_ext[QCNT_W-1:0];

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_on_q    <= BLINK_ON_RST;
			blink_gap_q   <= BLINK_GAP_RST;
			toggle_half_q <= TOGGLE_RST;
			level_q       <= 1'b0;
			mode_q        <= RUN_STEADY;
			timer_q       <= '0;
			left_q        <= '0;
			in_gap_q      <= 1'b0;
			fill_q        <= '0;
			seg_head_q    <= '0;
			seg_tail_q    <= '0;
			seg_cnt_q     <= '0;
			open_lvl_q    <= LVL_KEEP;
			open_tgl_q    <= 1'b0;
			open_cnt_q    <= '0;
			out_valid_q   <= 1'b0;
			skid_valid_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_BLINK_ON:  blink_on_q    <= cfg_data;
					CFG_BLINK_GAP: blink_gap_q   <= cfg_data;
					CFG_TOGGLE:    toggle_half_q <= cfg_data;
					default: ;
				endcase
			end
			level_q    <= level_d;
			mode_q     <= mode_d;
			timer_q    <= timer_d;
			left_q     <= left_d;
			in_gap_q   <= in_gap_d;
			fill_q     <= fill_d;
			open_lvl_q <= open_lvl_d;
			open_tgl_q <= open_tgl_d;
			open_cnt_q <= open_cnt_d;
			if (seg_push) begin
				seg_tail_q <= (seg_tail_q == PTR_LAST) ? '0 : seg_tail_q + 1'b1;
			end
			if (seg_pop) begin
				seg_head_q <= (seg_head_q == PTR_LAST) ? '0 : seg_head_q + 1'b1;
			end
			// push and pop never meet: pushes come with requests, pops with ticks
			if (seg_push) begin
				seg_cnt_q <= seg_cnt_q + 1'b1;
			end else if (seg_pop) begin
				seg_cnt_q <= seg_cnt_q - 1'b1;
			end

			if (skid_valid_q) begin
				if (take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (accept) begin
				if (out_valid_q && !take) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (seg_push) begin
			seg_mem_q[seg_tail_q] <= seg_new;
		end
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_valid_q && !take) begin
				skid_q <= res_new;
			end else begin
				out_q <= res_new;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign led_level       = out_q.led_level;
	assign mode            = out_q.mode;
	assign command_dropped = out_q.dropped;
	assign queued_commands = out_q.queued;

`ifndef NO_ASSERTIONS
	// queue only holds requests while a blink sequence runs
	a_queue_only_in_blink: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != RUN_BLINK) |-> (fill_q == '0 && seg_cnt_q == '0 && open_cnt_q == '0))
		else $error("queue not empty outside blink sequence");

	// every closed segment and the open one account for queued requests
	a_seg_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(FILL_W'(seg_cnt_q + open_cnt_q) <= fill_q))
		else $error("segment bookkeeping exceeds fill");

	// a running sequence always has a blink left and the gap state needs one
	a_blink_left: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == RUN_BLINK) |-> (left_q != '0))
		else $error("blink sequence with no blink left");

	a_gap_in_blink: assert property (@(posedge clk) disable iff (!arst_n)
		in_gap_q |-> (mode_q == RUN_BLINK))
		else $error("gap state outside blink sequence");

	// a dropped request is only reported with a full queue
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && dropped) |=> (fill_q == FILL_FULL && mode_q == RUN_BLINK))
		else $error("request dropped without full queue");
`endif

endmodule

// ===== test/led_pattern_controller_check.sv =====
`timescale 1ns / 100ps
module led_pattern_controller_check
	import lpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [CNT_W-1:0]  blink_count,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              led_level,
	input  logic [MODE_W-1:0] mode,
	input  logic              command_dropped,
	input  logic [QCNT_W-1:0] queued_commands,
	input  logic              cfg_write,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output int                mismatch_total,
	output int                results_owed
);

	logic [CFG_W-1:0]      on_len, gap_len, half_len;
	logic                  lvl;
	logic [MODE_W-1:0]     cur_mode;
	logic [TIMER_BITS-1:0] phase_tmr;
	logic [CNT_W-1:0]      blinks_todo;
	logic                  in_gap_phase;
	logic [ACT_W-1:0]      pend_act [FIFO_DEPTH];
	logic [CNT_W-1:0]      pend_cnt [FIFO_DEPTH];
	int                    pend_head, pend_fill;
	res_t                  led_expect_q [$];
	int                    miss_n = 0;

	// saturating tick; a limit past the timer range acts as its max
	function automatic logic timer_hit(logic [CFG_W-1:0] lim);
		if (phase_tmr != TMR_MAX)
			phase_tmr = phase_tmr + 1'b1;
		return (int'(phase_tmr) >= int'(lim)) || (phase_tmr == TMR_MAX);
	endfunction

	function automatic void run_cmd(logic [ACT_W-1:0] a, logic [CNT_W-1:0] c);
		case (a)
			ACT_ON: begin
				lvl = 1'b1;
				cur_mode = MODE_CODE_STEADY;
			end
			ACT_OFF: begin
				lvl = 1'b0;
				cur_mode = MODE_CODE_STEADY;
			end
			ACT_TOGGLE: begin
				cur_mode = MODE_CODE_TOGGLE;
				phase_tmr = '0;
			end
			ACT_BLINK: begin
				blinks_todo = (c == '0) ? CNT_W'(1) : c;
				lvl = ~lvl;
				in_gap_phase = 1'b0;
				phase_tmr = '0;
				cur_mode = MODE_CODE_BLINK;
			end
			default: cur_mode = MODE_CODE_STEADY;
		endcase
	endfunction

	// run queued requests until empty or until one starts a new blink
	function automatic void drain_pending();
		logic [ACT_W-1:0] a;
		logic [CNT_W-1:0] c;
		for (int g = 0; g < FIFO_DEPTH; g++) begin
			if (pend_fill == 0 || cur_mode == MODE_CODE_BLINK)
				break;
			a = pend_act[pend_head];
			c = pend_cnt[pend_head];
			pend_head = (pend_head + 1) % FIFO_DEPTH;
			pend_fill--;
			run_cmd(a, c);
		end
	endfunction

	function automatic void blink_tick();
		if (!in_gap_phase) begin
			if (timer_hit(on_len)) begin
				lvl = ~lvl;
				phase_tmr = '0;
				if (blinks_todo != '0)
					blinks_todo = blinks_todo - 1'b1;
				if (blinks_todo == '0) begin
					cur_mode = MODE_CODE_STEADY;
					drain_pending();
				end else begin
					in_gap_phase = 1'b1;
				end
			end
		end else if (timer_hit(gap_len)) begin
			lvl = ~lvl;
			phase_tmr = '0;
			in_gap_phase = 1'b0;
		end
	endfunction

	function automatic res_t step_led(logic [ACT_W-1:0] a, logic [CNT_W-1:0] c);
		res_t r;
		r.dropped = 1'b0;
		if (a == ACT_TICK) begin
			if (cur_mode == MODE_CODE_TOGGLE) begin
				if (timer_hit(half_len)) begin
					lvl = ~lvl;
					phase_tmr = '0;
				end
			end else if (cur_mode == MODE_CODE_BLINK) begin
				blink_tick();
			end
		end else if (cur_mode == MODE_CODE_BLINK) begin
			// queued behind the running sequence, lost when full
			if (pend_fill >= FIFO_DEPTH) begin
				r.dropped = 1'b1;
			end else begin
				pend_act[(pend_head + pend_fill) % FIFO_DEPTH] = a;
				pend_cnt[(pend_head + pend_fill) % FIFO_DEPTH] = c;
				pend_fill++;
			end
		end else begin
			run_cmd(a, c);
		end
		r.led_level = lvl;
		r.mode = cur_mode;
		r.queued = QCNT_W'(pend_fill);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			on_len = BLINK_ON_RST;
			gap_len = BLINK_GAP_RST;
			half_len = TOGGLE_RST;
			lvl = 1'b0;
			cur_mode = MODE_CODE_STEADY;
			phase_tmr = '0;
			blinks_todo = '0;
			in_gap_phase = 1'b0;
			pend_head = 0;
			pend_fill = 0;
			led_expect_q.delete();
			results_owed <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (led_expect_q.size() == 0) begin
					miss_n++;
					if (miss_n <= 10)
						$display("%0t: result with nothing pending: level %0b mode %0d drop %0b q %0d",
							$time, led_level, mode, command_dropped, queued_commands);
				end else begin
					want = led_expect_q.pop_front();
					if (led_level !== want.led_level || mode !== want.mode ||
						command_dropped !== want.dropped || queued_commands !== want.queued) begin
						miss_n++;
						if (miss_n <= 10)
							$display("%0t: mismatch: want level %0b mode %0d drop %0b q %0d, got level %0b mode %0d drop %0b q %0d",
								$time, want.led_level, want.mode, want.dropped, want.queued,
								led_level, mode, command_dropped, queued_commands);
					end
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					CFG_BLINK_ON:  on_len = cfg_data;
					CFG_BLINK_GAP: gap_len = cfg_data;
					CFG_TOGGLE:    half_len = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				led_expect_q.push_back(step_led(action, blink_count));
			results_owed <= led_expect_q.size();
			mismatch_total <= miss_n;
		end
	end

endmodule

// ===== test/led_pattern_controller_test.sv =====
`timescale 1ns / 100ps
module led_pattern_controller_test;
	import lpc_pkg::*;

	// far above the slowest legal run (about 420 requests under heavy stalls)
	localparam int CYCLE_LIMIT = 50000;
	localparam int RAND_PER_PHASE = 70;

	// actions 6 and 7 have no meaning and must behave as hold
	localparam logic [ACT_W-1:0] ACT_UNK6 = ACT_HOLD + 3'd1;
	localparam logic [ACT_W-1:0] ACT_UNK7 = ACT_HOLD + 3'd2;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [ACT_W-1:0]  action;
	logic [CNT_W-1:0]  blink_count;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              led_level;
	logic [MODE_W-1:0] mode;
	logic              command_dropped;
	logic [QCNT_W-1:0] queued_commands;
	logic              cfg_write;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	int mismatch_total;
	int results_owed;
	int cycle_count = 0;

	// per-phase pressure, percent of cycles
	int send_idle = 0;
	int recv_stall = 0;

	// random phases: no idling, sender idle, receiver stall, both
	int               idle_tab  [4] = '{0, 70, 0, 36};
	int               stall_tab [4] = '{0, 0, 70, 36};
	logic [CFG_W-1:0] on_tab    [4] = '{16'd1, 16'd2, 16'd3, 16'd1};
	logic [CFG_W-1:0] gap_tab   [4] = '{16'd1, 16'd3, 16'd1, 16'd2};
	logic [CFG_W-1:0] half_tab  [4] = '{16'd1, 16'd4, 16'd2, 16'd3};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	led_pattern_controller dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.blink_count     (blink_count),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.led_level       (led_level),
		.mode            (mode),
		.command_dropped (command_dropped),
		.queued_commands (queued_commands),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// scoreboard: predicts every accepted request and checks each result
	led_pattern_controller_check chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.blink_count     (blink_count),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.led_level       (led_level),
		.mode            (mode),
		.command_dropped (command_dropped),
		.queued_commands (queued_commands),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_total  (mismatch_total),
		.results_owed    (results_owed)
	);

	// receiver side: random backpressure, redrawn every cycle
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("led_pattern_controller_test NOT OK");
			$finish;
		end
	end

	// one request; valid holds with a fixed payload until accepted
	task automatic send_req(input logic [ACT_W-1:0] a, input logic [CNT_W-1:0] c);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		blink_count <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// stop sending and wait for every predicted result to come out;
	// the first edge lets the scoreboard count the last accepted request
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
	endtask

	// all three registers on consecutive edges, write strobe held high
	task automatic write_cfg(input logic [CFG_W-1:0] on_t, input logic [CFG_W-1:0] gap_t,
		input logic [CFG_W-1:0] half_t);
		cfg_write <= 1'b1;
		cfg_index <= CFG_BLINK_ON;
		cfg_data <= on_t;
		@(posedge clk);
		cfg_index <= CFG_BLINK_GAP;
		cfg_data <= gap_t;
		@(posedge clk);
		cfg_index <= CFG_TOGGLE;
		cfg_data <= half_t;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			send_req(ACT_TICK, CNT_W'($urandom));
	endtask

	// mostly ticks so sequences run to their end; blinks stay short so the
	// queue fills, overflows and drains; other requests carry random counts
	task automatic run_random(input int n);
		int r;
		logic [ACT_W-1:0] a;
		logic [CNT_W-1:0] c;
		repeat (n) begin
			r = $urandom_range(99);
			c = CNT_W'($urandom);
			if (r < 55) begin
				a = ACT_TICK;
			end else if (r < 70) begin
				a = ACT_BLINK;
				c = CNT_W'($urandom_range(0, 3));
			end else begin
				a = ACT_W'($urandom_range(int'(ACT_ON), (1 << ACT_W) - 1));
				if (a == ACT_BLINK)
					c = CNT_W'($urandom_range(0, 3));
			end
			send_req(a, c);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_TICK;
		blink_count = '0;
		cfg_write = 1'b0;
		cfg_index = CFG_BLINK_ON;
		cfg_data = '0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset durations: one blink of 100 ticks
		send_req(ACT_BLINK, CNT_W'(1));
		send_ticks(101);
		wait_drain();

		// directed: toggle half period 0 acts as 1
		write_cfg(16'd2, 16'd1, 16'd0);
		send_req(ACT_ON, '1);
		send_req(ACT_OFF, '0);
		send_req(ACT_TOGGLE, CNT_W'(20'hAAAAA));
		send_ticks(2);
		// toggle again while toggling: timer restarts, level kept
		send_req(ACT_TOGGLE, CNT_W'(20'h55555));
		send_ticks(1);
		// hold leaves toggle mode, then a tick while steady
		send_req(ACT_HOLD, '1);
		send_ticks(1);
		send_req(ACT_UNK6, CNT_W'(20'hAAAAA));
		send_req(ACT_UNK7, CNT_W'(20'h55555));
		// blink with everything queued behind it, one past a full queue
		send_req(ACT_BLINK, CNT_W'(2));
		send_req(ACT_ON, '0);
		send_req(ACT_TOGGLE, '1);
		send_req(ACT_UNK6, '0);
		send_req(ACT_UNK7, '1);
		send_req(ACT_BLINK, '0);
		send_req(ACT_HOLD, '0);
		send_req(ACT_OFF, '1);
		send_req(ACT_ON, '0);
		send_req(ACT_OFF, '1);
		// end of sequence drains up to the queued blink, then the rest
		send_ticks(7);
		wait_drain();

		for (int p = 0; p < 4; p++) begin
			write_cfg(on_tab[p], gap_tab[p], half_tab[p]);
			send_idle = idle_tab[p];
			recv_stall = stall_tab[p];
			run_random(RAND_PER_PHASE);
			// sender pauses here until the block has answered everything
			wait_drain();
		end

		// longest durations: neither timer runs out within a few ticks
		send_idle = 0;
		recv_stall = 0;
		write_cfg('1, '1, '1);
		send_req(ACT_TOGGLE, '0);
		send_ticks(3);
		// widest blink count: never ends, queued requests just pile up
		send_req(ACT_BLINK, '1);
		send_ticks(3);
		send_req(ACT_ON, '1);
		wait_drain();
		repeat (4)
			@(posedge clk);

		if (mismatch_total == 0)
			$display("led_pattern_controller_test OK");
		else
			$display("led_pattern_controller_test NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/lpc_pkg.sv
sv/led_pattern_controller.sv
test/led_pattern_controller_check.sv
test/led_pattern_controller_test.sv
